// ----- rtl/core/vams_pkg.sv -----
package vams_pkg;

    localparam int COORD_W = 24;
    localparam int FEAT_W = 5;
    localparam int VALUE_W = 20;
    localparam int STATUS_W = 2;
    localparam int CORDIC_STEPS = 24;
    localparam int ATAN_W = 27;

    localparam logic [1:0] FUNC_ANGLE = 2'd0;
    localparam logic [1:0] FUNC_SCALE = 2'd1;
    localparam logic [1:0] FUNC_LOAD = 2'd2;
    localparam logic [1:0] FUNC_RSVD = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ZERO_VEC = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ZERO_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_SAT = 2'd3;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0] func;
        logic [FEAT_W-1:0] feature;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
    } vams_req_t;

    typedef struct packed {
        logic [FEAT_W-1:0] feature_out;
        logic signed [VALUE_W-1:0] scaled_value;
        logic [STATUS_W-1:0] status;
    } vams_rsp_t;

    // Control and operands that ride alongside the datapath.
    typedef struct packed {
        logic [1:0] func;
        logic [FEAT_W-1:0] feature;
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic zero;
        logic dneg;
        logic bad;
        logic sneg;
    } vams_side_t;

    // Arctangent of 2^-i in degrees, Q20.
    function automatic logic [ATAN_W-1:0] atan_q20(input int unsigned i);
        logic [ATAN_W-1:0] v;
        unique case (i)
            0: v = 27'd47185920;
            1: v = 27'd27855475;
            2: v = 27'd14718068;
            3: v = 27'd7471121;
            4: v = 27'd3750058;
            5: v = 27'd1876857;
            6: v = 27'd938658;
            7: v = 27'd469357;
            8: v = 27'd234682;
            9: v = 27'd117342;
            10: v = 27'd58671;
            11: v = 27'd29335;
            12: v = 27'd14668;
            13: v = 27'd7334;
            14: v = 27'd3667;
            15: v = 27'd1833;
            16: v = 27'd917;
            17: v = 27'd458;
            18: v = 27'd229;
            19: v = 27'd115;
            20: v = 27'd57;
            21: v = 27'd29;
            22: v = 27'd14;
            23: v = 27'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/vector_angle_min_max_scaler.sv -----
// Feature engine: angle between two 3-D vectors, or a raw coordinate, min-max scaled through a
// per-feature table. It takes one beat per clock cycle while the output is not stalled; the
// pipeline depth is set by the fully pipelined square roots, the 30-step cosine divider,
// the 24-step CORDIC and the 21-step scaling divider, one step per stage. A stalled output
// freezes the whole pipeline. A table load takes effect for every beat accepted after it.
module vector_angle_min_max_scaler #(
    parameter int NUM_FEATURES = 32
) (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    output logic req_ready,
    input vams_pkg::vams_req_t req,
    output logic rsp_valid,
    input logic rsp_ready,
    output vams_pkg::vams_rsp_t rsp
);

    import vams_pkg::*;

    localparam int AW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int PROD_W = 2 * COORD_W;
    localparam int SQA_STEPS = COORD_W;
    localparam int ROOTA_W = COORD_W;
    localparam int REMA_W = ROOTA_W + 2;
    localparam int DIV_STEPS = 30;
    localparam int C_W = DIV_STEPS + 1;
    localparam int CSQ_W = 2 * C_W;
    localparam int SQC_STEPS = C_W;
    localparam int ROOTC_W = C_W;
    localparam int REMC_W = ROOTC_W + 2;
    localparam int XY_W = C_W + 3;
    localparam int Z_W = ATAN_W + 2;
    localparam int SCALE_FRAC = 16;
    localparam int QBITS = VALUE_W + 1;
    localparam int DIFF_W = COORD_W + 1;
    localparam int UN_W = COORD_W + SCALE_FRAC + 2;

    localparam int ST_MUL = 1;
    localparam int ST_SUM = 2;
    localparam int ST_SQA = 3;
    localparam int ST_D = ST_SQA + SQA_STEPS;
    localparam int ST_CAP = ST_D + 1;
    localparam int ST_DIV = ST_CAP + 1;
    localparam int ST_CSQ = ST_DIV + DIV_STEPS;
    localparam int ST_T = ST_CSQ + 1;
    localparam int ST_SQC = ST_T + 1;
    localparam int ST_COR = ST_SQC + SQC_STEPS;
    localparam int ST_ANG = ST_COR + CORDIC_STEPS;
    localparam int ST_RD = ST_ANG + 1;
    localparam int ST_DIFF = ST_RD + 1;
    localparam int ST_UN = ST_DIFF + 1;
    localparam int ST_OVF = ST_UN + 1;
    localparam int ST_Q = ST_OVF + 1;
    localparam int NSTG = ST_Q + QBITS;

    localparam logic [C_W-1:0] ONE_Q30 = {1'b1, {DIV_STEPS{1'b0}}};
    localparam logic [CSQ_W-1:0] ONE_Q60 = {2'b01, {(CSQ_W-2){1'b0}}};
    localparam logic signed [Z_W-1:0] DEG90 = Z_W'(90 * (2 ** 20));
    localparam logic signed [Z_W-1:0] DEG180 = Z_W'(180 * (2 ** 20));
    localparam logic [QBITS-1:0] POS_LIM = QBITS'(2 ** (VALUE_W - 1) - 1);
    localparam logic [QBITS-1:0] NEG_LIM = QBITS'(2 ** (VALUE_W - 1));

    logic adv;
    logic [NSTG-1:0] v_reg;
    vams_side_t side_reg [NSTG];
    vams_side_t side_next [NSTG];
    logic rsp_valid_reg;
    vams_rsp_t rsp_reg;

    assign adv = !rsp_valid_reg || rsp_ready;
    assign req_ready = adv;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NSTG-2:0], req_valid && (req.func != FUNC_RSVD)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // Input stage and products.
    logic signed [COORD_W-1:0] va_reg [3];
    logic signed [COORD_W-1:0] vb_reg [3];
    logic signed [PROD_W-1:0] prod_reg [9];
    logic mul_zero;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            va_reg[0] <= req.first_x;
            va_reg[1] <= req.first_y;
            va_reg[2] <= req.first_z;
            vb_reg[0] <= req.second_x;
            vb_reg[1] <= req.second_y;
            vb_reg[2] <= req.second_z;
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= va_reg[i] * vb_reg[i];
                prod_reg[3+i] <= va_reg[i] * va_reg[i];
                prod_reg[6+i] <= vb_reg[i] * vb_reg[i];
            end
        end
    end

    assign mul_zero = (va_reg[0] == '0 && va_reg[1] == '0 && va_reg[2] == '0)
                   || (vb_reg[0] == '0 && vb_reg[1] == '0 && vb_reg[2] == '0);

    // Sums.
    logic signed [PROD_W+1:0] dot_sum;
    logic [PROD_W+1:0] dot_mag;
    logic [PROD_W-1:0] r_reg;
    logic [PROD_W-1:0] na_reg;
    logic [PROD_W-1:0] nb_reg;

    assign dot_sum = (PROD_W+2)'(prod_reg[0]) + (PROD_W+2)'(prod_reg[1])
                   + (PROD_W+2)'(prod_reg[2]);
    assign dot_mag = $unsigned(dot_sum[PROD_W+1] ? -dot_sum : dot_sum);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg <= dot_mag[PROD_W-1:0];
            na_reg <= $unsigned(prod_reg[3]) + $unsigned(prod_reg[4]) + $unsigned(prod_reg[5]);
            nb_reg <= $unsigned(prod_reg[6]) + $unsigned(prod_reg[7]) + $unsigned(prod_reg[8]);
        end
    end

    // Square roots of both norms, one result bit per stage.
    logic [PROD_W-1:0] sqa_n_reg [2][SQA_STEPS];
    logic [REMA_W-1:0] sqa_rem_reg [2][SQA_STEPS];
    logic [ROOTA_W-1:0] sqa_root_reg [2][SQA_STEPS];
    logic [PROD_W-1:0] sqa_r_reg [SQA_STEPS];

    for (genvar u = 0; u < 2; u++)
    begin : g_sqa_u
        for (genvar j = 0; j < SQA_STEPS; j++)
        begin : g_step
            logic [PROD_W-1:0] n_in;
            logic [REMA_W-1:0] rem_in;
            logic [ROOTA_W-1:0] root_in;
            logic [REMA_W+1:0] cand;
            logic [REMA_W+1:0] trial;
            logic ge;
            if (j == 0)
            begin : g_first
                assign n_in = (u == 0) ? na_reg : nb_reg;
                assign rem_in = '0;
                assign root_in = '0;
            end
            else
            begin : g_next
                assign n_in = sqa_n_reg[u][j-1];
                assign rem_in = sqa_rem_reg[u][j-1];
                assign root_in = sqa_root_reg[u][j-1];
            end
            assign cand = {rem_in, n_in[PROD_W-1-2*j -: 2]};
            assign trial = (REMA_W+2)'({root_in, 2'b01});
            assign ge = cand >= trial;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sqa_n_reg[u][j] <= n_in;
                    sqa_rem_reg[u][j] <= ge ? REMA_W'(cand - trial) : REMA_W'(cand);
                    sqa_root_reg[u][j] <= {root_in[ROOTA_W-2:0], ge};
                end
            end
        end
    end

    for (genvar j = 0; j < SQA_STEPS; j++)
    begin : g_sqa_r
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sqa_r_reg[j] <= (j == 0) ? r_reg : sqa_r_reg[(j == 0) ? 0 : j-1];
            end
        end
    end

    // Norm product and cap check.
    logic [PROD_W-1:0] d_reg;
    logic [PROD_W-1:0] r_d_reg;
    logic [PROD_W-1:0] d_cap_reg;
    logic [PROD_W-1:0] r_cap_reg;
    logic cap_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= sqa_root_reg[0][SQA_STEPS-1] * sqa_root_reg[1][SQA_STEPS-1];
            r_d_reg <= sqa_r_reg[SQA_STEPS-1];
            cap_reg <= r_d_reg >= d_reg;
            d_cap_reg <= d_reg;
            r_cap_reg <= r_d_reg;
        end
    end

    // Cosine divider, one quotient bit per stage.
    logic [PROD_W-1:0] div_rem_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] div_q_reg [DIV_STEPS];
    logic [PROD_W-1:0] div_d_reg [DIV_STEPS];
    logic div_cap_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [PROD_W-1:0] rem_in;
        logic [DIV_STEPS-1:0] q_in;
        logic [PROD_W-1:0] d_in;
        logic cap_in;
        logic [PROD_W:0] rem2;
        logic ge;
        if (j == 0)
        begin : g_first
            assign rem_in = r_cap_reg;
            assign q_in = '0;
            assign d_in = d_cap_reg;
            assign cap_in = cap_reg;
        end
        else
        begin : g_next
            assign rem_in = div_rem_reg[j-1];
            assign q_in = div_q_reg[j-1];
            assign d_in = div_d_reg[j-1];
            assign cap_in = div_cap_reg[j-1];
        end
        assign rem2 = {rem_in, 1'b0};
        assign ge = rem2 >= {1'b0, d_in};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_rem_reg[j] <= ge ? PROD_W'(rem2 - {1'b0, d_in}) : PROD_W'(rem2);
                div_q_reg[j] <= {q_in[DIV_STEPS-2:0], ge};
                div_d_reg[j] <= d_in;
                div_cap_reg[j] <= cap_in;
            end
        end
    end

    // Sine from the cosine.
    logic [C_W-1:0] c_val;
    logic [C_W-1:0] c_csq_reg;
    logic [CSQ_W-1:0] csq_reg;
    logic [C_W-1:0] c_t_reg;
    logic [CSQ_W-1:0] t_reg;

    assign c_val = div_cap_reg[DIV_STEPS-1] ? ONE_Q30 : {1'b0, div_q_reg[DIV_STEPS-1]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_csq_reg <= c_val;
            csq_reg <= c_val * c_val;
            c_t_reg <= c_csq_reg;
            t_reg <= ONE_Q60 - csq_reg;
        end
    end

    logic [CSQ_W-1:0] sqc_n_reg [SQC_STEPS];
    logic [REMC_W-1:0] sqc_rem_reg [SQC_STEPS];
    logic [ROOTC_W-1:0] sqc_root_reg [SQC_STEPS];
    logic [C_W-1:0] sqc_c_reg [SQC_STEPS];

    for (genvar j = 0; j < SQC_STEPS; j++)
    begin : g_sqc
        logic [CSQ_W-1:0] n_in;
        logic [REMC_W-1:0] rem_in;
        logic [ROOTC_W-1:0] root_in;
        logic [C_W-1:0] c_in;
        logic [REMC_W+1:0] cand;
        logic [REMC_W+1:0] trial;
        logic ge;
        if (j == 0)
        begin : g_first
            assign n_in = t_reg;
            assign rem_in = '0;
            assign root_in = '0;
            assign c_in = c_t_reg;
        end
        else
        begin : g_next
            assign n_in = sqc_n_reg[j-1];
            assign rem_in = sqc_rem_reg[j-1];
            assign root_in = sqc_root_reg[j-1];
            assign c_in = sqc_c_reg[j-1];
        end
        assign cand = {rem_in, n_in[CSQ_W-1-2*j -: 2]};
        assign trial = (REMC_W+2)'({root_in, 2'b01});
        assign ge = cand >= trial;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sqc_n_reg[j] <= n_in;
                sqc_rem_reg[j] <= ge ? REMC_W'(cand - trial) : REMC_W'(cand);
                sqc_root_reg[j] <= {root_in[ROOTC_W-2:0], ge};
                sqc_c_reg[j] <= c_in;
            end
        end
    end

    // CORDIC vectoring, one rotation per stage.
    logic signed [XY_W-1:0] cor_x_reg [CORDIC_STEPS];
    logic signed [XY_W-1:0] cor_y_reg [CORDIC_STEPS];
    logic signed [Z_W-1:0] cor_z_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cor
        logic signed [XY_W-1:0] x_in;
        logic signed [XY_W-1:0] y_in;
        logic signed [Z_W-1:0] z_in;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [Z_W-1:0] tz;
        logic pos;
        if (i == 0)
        begin : g_first
            assign x_in = $signed(XY_W'(sqc_c_reg[SQC_STEPS-1]));
            assign y_in = $signed(XY_W'(sqc_root_reg[SQC_STEPS-1]));
            assign z_in = '0;
        end
        else
        begin : g_next
            assign x_in = cor_x_reg[i-1];
            assign y_in = cor_y_reg[i-1];
            assign z_in = cor_z_reg[i-1];
        end
        assign dx = y_in >>> i;
        assign dy = x_in >>> i;
        assign tz = $signed(Z_W'(atan_q20(i)));
        assign pos = !y_in[XY_W-1];
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cor_x_reg[i] <= pos ? x_in + dx : x_in - dx;
                cor_y_reg[i] <= pos ? y_in - dy : y_in + dy;
                cor_z_reg[i] <= pos ? z_in + tz : z_in - tz;
            end
        end
    end

    // Angle in degrees, Q12.12.
    logic signed [Z_W-1:0] z_clamp;
    logic signed [Z_W-1:0] z_fin;
    logic signed [Z_W-1:0] z_rnd;
    logic signed [COORD_W-1:0] ang_val;

    always_comb
    begin
        priority if (cor_z_reg[CORDIC_STEPS-1] < 0)
        begin
            z_clamp = '0;
        end
        else if (cor_z_reg[CORDIC_STEPS-1] > DEG90)
        begin
            z_clamp = DEG90;
        end
        else
        begin
            z_clamp = cor_z_reg[CORDIC_STEPS-1];
        end
        z_fin = side_reg[ST_ANG-1].dneg ? DEG180 - z_clamp : z_clamp;
        z_rnd = (z_fin + Z_W'(128)) >>> 8;
        ang_val = COORD_W'(z_rnd);
    end

    // Scaler table, written and read at the same stage so that beats see loads in order.
    logic in_range_ang;
    logic in_range_rd;
    logic tbl_we;
    logic [2*COORD_W-1:0] tbl_rdata;
    logic signed [COORD_W-1:0] tbl_min;
    logic signed [COORD_W-1:0] tbl_max;

    assign in_range_ang = int'(side_reg[ST_ANG].feature) < NUM_FEATURES;
    assign in_range_rd = int'(side_reg[ST_RD].feature) < NUM_FEATURES;
    assign tbl_we = adv && v_reg[ST_ANG] && (side_reg[ST_ANG].func == FUNC_LOAD) && in_range_ang;
    assign tbl_min = $signed(tbl_rdata[COORD_W-1:0]);
    assign tbl_max = $signed(tbl_rdata[2*COORD_W-1:COORD_W]);

    vams_ram #(
        .WIDTH(2 * COORD_W),
        .DEPTH(NUM_FEATURES)
    ) u_table (
        .clk(clk),
        .we(tbl_we),
        .waddr(AW'(side_reg[ST_ANG].feature)),
        .wdata({side_reg[ST_ANG].fy, side_reg[ST_ANG].fx}),
        .re(adv),
        .raddr(AW'(side_reg[ST_ANG].feature)),
        .rdata(tbl_rdata)
    );

    // Scaling: operands, rounding bias and overflow check.
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W-1:0] den_reg;
    logic [DIFF_W-1:0] abs_diff;
    logic [DIFF_W-1:0] abs_den;
    logic [UN_W-1:0] un_reg;
    logic [DIFF_W-1:0] ud_reg;
    logic [UN_W-1:0] un_ovf_reg;
    logic [DIFF_W-1:0] ud_ovf_reg;
    logic [DIFF_W-1:0] rem_ovf_reg;
    logic ovf_reg;

    assign abs_diff = $unsigned(diff_reg[DIFF_W-1] ? -diff_reg : diff_reg);
    assign abs_den = $unsigned(den_reg[DIFF_W-1] ? -den_reg : den_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg <= DIFF_W'(side_reg[ST_RD].fx) - DIFF_W'(tbl_min);
            den_reg <= DIFF_W'(tbl_max) - DIFF_W'(tbl_min);
            un_reg <= UN_W'({abs_diff, {SCALE_FRAC{1'b0}}}) + UN_W'(abs_den >> 1);
            ud_reg <= abs_den;
            ovf_reg <= (UN_W + QBITS)'(un_reg) >= ((UN_W + QBITS)'(ud_reg) << QBITS);
            un_ovf_reg <= un_reg;
            ud_ovf_reg <= ud_reg;
            rem_ovf_reg <= DIFF_W'(un_reg >> QBITS);
        end
    end

    // Scaling divider, one quotient bit per stage.
    logic [DIFF_W-1:0] q_rem_reg [QBITS];
    logic [QBITS-1:0] q_q_reg [QBITS];
    logic [UN_W-1:0] q_n_reg [QBITS];
    logic [DIFF_W-1:0] q_d_reg [QBITS];
    logic q_ovf_reg [QBITS];

    for (genvar j = 0; j < QBITS; j++)
    begin : g_qdiv
        logic [DIFF_W-1:0] rem_in;
        logic [QBITS-1:0] q_in;
        logic [UN_W-1:0] n_in;
        logic [DIFF_W-1:0] d_in;
        logic ovf_in;
        logic [DIFF_W:0] rem2;
        logic ge;
        if (j == 0)
        begin : g_first
            assign rem_in = rem_ovf_reg;
            assign q_in = '0;
            assign n_in = un_ovf_reg;
            assign d_in = ud_ovf_reg;
            assign ovf_in = ovf_reg;
        end
        else
        begin : g_next
            assign rem_in = q_rem_reg[j-1];
            assign q_in = q_q_reg[j-1];
            assign n_in = q_n_reg[j-1];
            assign d_in = q_d_reg[j-1];
            assign ovf_in = q_ovf_reg[j-1];
        end
        assign rem2 = {rem_in, n_in[QBITS-1-j]};
        assign ge = rem2 >= {1'b0, d_in};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_rem_reg[j] <= ge ? DIFF_W'(rem2 - {1'b0, d_in}) : DIFF_W'(rem2);
                q_q_reg[j] <= {q_in[QBITS-2:0], ge};
                q_n_reg[j] <= n_in;
                q_d_reg[j] <= d_in;
                q_ovf_reg[j] <= ovf_in;
            end
        end
    end

    // Side channel updates along the pipeline.
    always_comb
    begin
        side_next[0].func = req.func;
        side_next[0].feature = req.feature;
        side_next[0].fx = req.first_x;
        side_next[0].fy = req.first_y;
        side_next[0].zero = 1'b0;
        side_next[0].dneg = 1'b0;
        side_next[0].bad = 1'b0;
        side_next[0].sneg = 1'b0;
    end

    for (genvar k = 1; k < NSTG; k++)
    begin : g_side
        always_comb
        begin
            side_next[k] = side_reg[k-1];
            if (k == ST_MUL)
            begin
                side_next[k].zero = mul_zero;
            end
            if (k == ST_SUM)
            begin
                side_next[k].dneg = dot_sum[PROD_W+1];
            end
            if (k == ST_ANG && side_reg[k-1].func == FUNC_ANGLE)
            begin
                side_next[k].fx = ang_val;
            end
            if (k == ST_DIFF)
            begin
                side_next[k].bad = !in_range_rd || (tbl_max == tbl_min);
            end
            if (k == ST_UN)
            begin
                side_next[k].sneg = diff_reg[DIFF_W-1] != den_reg[DIFF_W-1];
            end
        end
    end

    // Result selection and output register.
    vams_side_t side_last;
    logic [QBITS-1:0] q_last;
    logic signed [QBITS:0] q_signed;
    vams_rsp_t rsp_next;

    assign side_last = side_reg[NSTG-1];
    assign q_last = q_q_reg[QBITS-1];
    assign q_signed = $signed({1'b0, q_last});

    always_comb
    begin
        rsp_next.feature_out = side_last.feature;
        priority if (side_last.func == FUNC_ANGLE && side_last.zero)
        begin
            rsp_next.scaled_value = '0;
            rsp_next.status = STAT_ZERO_VEC;
        end
        else if (side_last.bad)
        begin
            rsp_next.scaled_value = '0;
            rsp_next.status = STAT_ZERO_RANGE;
        end
        else if (q_ovf_reg[QBITS-1] || (!side_last.sneg && q_last > POS_LIM)
                 || (side_last.sneg && q_last > NEG_LIM))
        begin
            rsp_next.scaled_value = side_last.sneg ? VALUE_MIN : VALUE_MAX;
            rsp_next.status = STAT_SAT;
        end
        else
        begin
            rsp_next.scaled_value = VALUE_W'(side_last.sneg ? -q_signed : q_signed);
            rsp_next.status = STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= v_reg[NSTG-1]
                && (side_last.func == FUNC_ANGLE || side_last.func == FUNC_SCALE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ----- rtl/core/vams_ram.sv -----
module vams_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input logic clk,
    input logic we,
    input logic [AW-1:0] waddr,
    input logic [WIDTH-1:0] wdata,
    input logic re,
    input logic [AW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/vams_checker.sv -----
module vams_checker (
    input logic clk,
    input logic rst_n,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input vams_pkg::vams_rsp_t rsp
);

    import vams_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("Result beat changed or dropped while stalled.");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STAT_ZERO_VEC || rsp.status == STAT_ZERO_RANGE)
        |-> rsp.scaled_value == '0)
        else $error("Flagged result carries a non-zero value.");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_SAT
        |-> (rsp.scaled_value == VALUE_MAX || rsp.scaled_value == VALUE_MIN))
        else $error("Saturated result is not at a limit.");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("Input stalled without an output stall.");

endmodule

bind vector_angle_min_max_scaler vams_checker u_vams_checker (
    .clk(clk),
    .rst_n(rst_n),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
);
